FILE: rtl/potg_pkg.sv
package potg_pkg;

  localparam int GRID_ROWS  = 128;
  localparam int GRID_COLS  = 128;
  localparam int PIXEL_BITS = 11;

  localparam int ROW_W     = $clog2(GRID_ROWS);
  localparam int COL_W     = $clog2(GRID_COLS);
  localparam int DEPTH     = GRID_ROWS * GRID_COLS;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int FIELD_W   = 7;
  localparam int CELL_W    = 8;
  localparam int PIX_W     = 11;
  localparam int HALF_COLS = GRID_COLS / 2;

  localparam logic [CELL_W-1:0] HIT_GAIN = 8'd80;

  // Divider: numerator 2*a*cpm*16 + den, divisor 2*den
  localparam int NUM_W = 46;
  localparam int DEN_W = 17;

  // Distance in cells (Q.16) stays below GRID_ROWS once the row check passes
  localparam int DQ_W   = ROW_W + 16;
  localparam int TAN_W  = 24;
  localparam int PROD_W = DQ_W + TAN_W;
  localparam int MAG_W  = PROD_W + 1 - 32;

  localparam int TAN_STEPS = 1440;
  localparam int TAN_AW    = $clog2(TAN_STEPS + 1);
  localparam int IDX_W     = 16;
  localparam logic [IDX_W-1:0] TURN_STEPS = IDX_W'(2 * TAN_STEPS);
  localparam logic [IDX_W-1:0] HALF_STEPS = IDX_W'(TAN_STEPS);
  localparam int BEAR_W    = 30;
  localparam logic [BEAR_W-1:0] BEAR_BIAS = BEAR_W'(2048 + 4096 * 2 * TAN_STEPS);

  typedef enum logic [1:0] {
    OP_HIT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_OFF_GRID = 2'd1,
    ST_NO_DIST  = 2'd2
  } status_e;

  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_DIST_NUM   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROW_OFFSET = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BEAR_GAIN  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BEAR_OFF   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CELLS_PM   = 3'd4;

  localparam logic [23:0] RST_DIST_NUM   = 24'd68864;
  localparam logic [15:0] RST_ROW_OFFSET = 16'(-4810);
  localparam logic [15:0] RST_BEAR_GAIN  = 16'd5574;
  localparam logic [15:0] RST_BEAR_OFF   = 16'(-13429);
  localparam logic [15:0] RST_CELLS_PM   = 16'd5120;

  typedef logic [TAN_W-1:0] tan_tab_t [0:TAN_STEPS];

  localparam longint PI_Q30  = 64'sd3373259426;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint TAN_MAX = 64'sd16777215;

  // Shift-subtract quotient of a nonnegative dividend below 2^48 by a positive divisor
  function automatic longint udiv(longint a, longint b);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int i = 47; i >= 0; i--) begin
      r = (r <<< 1) | ((a >>> i) & 64'sd1);
      q = q <<< 1;
      if (r >= b) begin
        r = r - b;
        q = q | 64'sd1;
      end
    end
    return q;
  endfunction

  // Tangent in Q8.16 for 1/16 degree steps, sin and cos from a Q30 series
  function automatic tan_tab_t build_tan();
    tan_tab_t tab;
    longint x;
    longint ts;
    longint tc;
    longint s;
    longint c;
    longint t;
    for (int k = 0; k < TAN_STEPS; k++) begin
      x  = udiv(longint'(k) * PI_Q30 + longint'(TAN_STEPS), longint'(2 * TAN_STEPS));
      ts = x;
      tc = ONE_Q30;
      s  = x;
      c  = ONE_Q30;
      for (int n = 1; n <= 10; n++) begin
        ts = udiv(((ts * x) >>> 30) * x >>> 30, longint'((2 * n) * (2 * n + 1)));
        tc = udiv(((tc * x) >>> 30) * x >>> 30, longint'((2 * n - 1) * (2 * n)));
        if ((n & 1) == 1) begin
          s = s - ts;
          c = c - tc;
        end else begin
          s = s + ts;
          c = c + tc;
        end
      end
      if (s < 0) s = 0;
      if (c <= 0) begin
        t = TAN_MAX;
      end else begin
        t = udiv(s * 65536 + (c >>> 1), c);
        if (t > TAN_MAX) t = TAN_MAX;
      end
      tab[k] = TAN_W'(t);
    end
    tab[TAN_STEPS] = TAN_W'(TAN_MAX);
    return tab;
  endfunction

  localparam tan_tab_t TAN_TABLE = build_tan();

endpackage

FILE: rtl/potg_ram.sv
module potg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/potg_div.sv
module potg_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [potg_pkg::NUM_W-1:0]  num_i,
  input  logic [potg_pkg::DEN_W-1:0]  den_i,
  output logic                        done_o,
  output logic [potg_pkg::NUM_W-1:0]  quo_o
);

  localparam int CNT_W = $clog2(potg_pkg::NUM_W + 1);

  logic                       busy_q;
  logic                       done_q;
  logic [CNT_W-1:0]           cnt_q;
  logic [potg_pkg::DEN_W-1:0] rem_q;
  logic [potg_pkg::DEN_W-1:0] den_q;
  logic [potg_pkg::NUM_W-1:0] quo_q;
  logic [potg_pkg::DEN_W:0]   trial;
  logic [potg_pkg::DEN_W:0]   diff;
  logic                       fits;

  // One quotient bit a cycle, restoring
  assign trial = {rem_q, quo_q[potg_pkg::NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(potg_pkg::NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[potg_pkg::DEN_W-1:0] : trial[potg_pkg::DEN_W-1:0];
      quo_q <= {quo_q[potg_pkg::NUM_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: rtl/pixel_to_occupancy_grid_accumulator_unit.sv
// Per request: an on-grid hit runs the bit-serial divider and up to 13 bearing index turn
//   subtractions before its result; an off-grid hit stops at the row or column check, a hit
//   with no ground distance stops before the divider, and a grid clear sweeps the cell RAM.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: registers take their reset values, then a clearing pass over all GRID_ROWS*GRID_COLS
//   cells zeroes the cell RAM while no request is taken.
module pixel_to_occupancy_grid_accumulator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pixel_column[10:0], pixel_row[21:11], query_row[28:22], query_col[35:29]
  input  logic [39:0] s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // cell_row[6:0], cell_col[13:7], cell_value[21:14]
  output logic [23:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]  m_axis_tuser
);

  typedef enum logic [12:0] {
    S_CLR  = 13'b0000000000001,
    S_IDLE = 13'b0000000000010,
    S_DISP = 13'b0000000000100,
    S_DEN  = 13'b0000000001000,
    S_DIV  = 13'b0000000010000,
    S_ROW  = 13'b0000000100000,
    S_MOD  = 13'b0000001000000,
    S_MUL  = 13'b0000010000000,
    S_COL  = 13'b0000100000000,
    S_UPD  = 13'b0001000000000,
    S_QRD  = 13'b0010000000000,
    S_DONE = 13'b0100000000000,
    S_WAIT = 13'b1000000000000
  } state_e;

  localparam int MODW = potg_pkg::IDX_W;

  state_e state_q, state_d;

  logic [23:0] dist_num_q;
  logic [15:0] row_off_q;
  logic [15:0] bear_gain_q;
  logic [15:0] bear_off_q;
  logic [15:0] cells_pm_q;

  potg_pkg::opcode_e              op_q;
  logic [potg_pkg::PIX_W-1:0]     x_q;
  logic [potg_pkg::PIX_W-1:0]     y_q;
  logic [potg_pkg::FIELD_W-1:0]   qrow_q;
  logic [potg_pkg::FIELD_W-1:0]   qcol_q;

  logic [39:0]                    num_q;
  logic [potg_pkg::DEN_W-1:0]     den_q;
  logic [potg_pkg::BEAR_W-1:0]    bear_q;
  logic [potg_pkg::NUM_W-1:0]     dq_q;
  logic [MODW-1:0]                idx_q;
  logic                           neg_q;
  logic [potg_pkg::TAN_W-1:0]     tan_q;
  logic [potg_pkg::PROD_W-1:0]    prod_q;
  logic [potg_pkg::ROW_W-1:0]     row_q;
  logic [potg_pkg::COL_W-1:0]     col_q;
  logic [potg_pkg::ADDR_W-1:0]    addr_q;
  logic [potg_pkg::ADDR_W-1:0]    clr_cnt_q;
  logic                           clr_op_q;

  potg_pkg::status_e              res_st_q;
  logic [potg_pkg::FIELD_W-1:0]   res_row_q;
  logic [potg_pkg::FIELD_W-1:0]   res_col_q;
  logic [potg_pkg::CELL_W-1:0]    res_val_q;

  logic                           out_valid_q;
  potg_pkg::status_e              out_st_q;
  logic [potg_pkg::FIELD_W-1:0]   out_row_q;
  logic [potg_pkg::FIELD_W-1:0]   out_col_q;
  logic [potg_pkg::CELL_W-1:0]    out_val_q;
  logic                           out_free;

  logic                           div_start;
  logic                           div_done;
  logic [potg_pkg::NUM_W-1:0]     div_quo;
  logic [potg_pkg::NUM_W-1:0]     div_num;
  logic [potg_pkg::NUM_W-1:0]     row_sum;
  logic                           row_ok;
  logic [potg_pkg::BEAR_W-1:0]    bear_biased;
  logic [potg_pkg::TAN_AW-1:0]    tan_addr;
  logic [potg_pkg::PROD_W:0]      prod_rnd;
  logic [potg_pkg::MAG_W-1:0]     mag;
  logic signed [potg_pkg::MAG_W+1:0] col_s;
  logic                           col_ok;
  logic                           den_pos;
  logic                           q_ok;
  logic [potg_pkg::PIX_W-1:0]     pix_mask;

  logic                           ram_we;
  logic [potg_pkg::ADDR_W-1:0]    ram_waddr;
  logic [potg_pkg::CELL_W-1:0]    ram_wdata;
  logic [potg_pkg::ADDR_W-1:0]    ram_raddr;
  logic [potg_pkg::CELL_W-1:0]    ram_rdata;
  logic [potg_pkg::CELL_W-1:0]    cell_sum;

  assign pix_mask = potg_pkg::PIX_W'((1 << potg_pkg::PIXEL_BITS) - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_num_q  <= potg_pkg::RST_DIST_NUM;
      row_off_q   <= potg_pkg::RST_ROW_OFFSET;
      bear_gain_q <= potg_pkg::RST_BEAR_GAIN;
      bear_off_q  <= potg_pkg::RST_BEAR_OFF;
      cells_pm_q  <= potg_pkg::RST_CELLS_PM;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        potg_pkg::REG_DIST_NUM:   dist_num_q  <= cfg_wdata_i;
        potg_pkg::REG_ROW_OFFSET: row_off_q   <= cfg_wdata_i[15:0];
        potg_pkg::REG_BEAR_GAIN:  bear_gain_q <= cfg_wdata_i[15:0];
        potg_pkg::REG_BEAR_OFF:   bear_off_q  <= cfg_wdata_i[15:0];
        potg_pkg::REG_CELLS_PM:   cells_pm_q  <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_q || m_axis_tready;

  assign den_pos  = !den_q[potg_pkg::DEN_W-1] && (den_q != '0);
  assign div_num  = {2'b0, num_q, 4'b0} + {1'b0, num_q, 5'b0} - {2'b0, num_q, 4'b0}
                    + potg_pkg::NUM_W'(den_q);
  assign div_start = (state_q == S_DEN) && den_pos;

  assign row_sum = dq_q + potg_pkg::NUM_W'(32768);
  assign row_ok  = row_sum[potg_pkg::NUM_W-1:16] < (potg_pkg::NUM_W - 16)'(potg_pkg::GRID_ROWS);

  assign bear_biased = bear_q + potg_pkg::BEAR_BIAS;

  // Fold the upper half turn onto the table with a sign
  assign tan_addr = (idx_q >= potg_pkg::HALF_STEPS)
                    ? potg_pkg::TAN_AW'(potg_pkg::TURN_STEPS - idx_q)
                    : potg_pkg::TAN_AW'(idx_q);

  assign prod_rnd = {1'b0, prod_q} + (potg_pkg::PROD_W + 1)'(64'h80000000);
  assign mag      = prod_rnd[potg_pkg::PROD_W:32];
  assign col_s    = neg_q
                    ? (potg_pkg::MAG_W + 2)'(potg_pkg::HALF_COLS) - {2'b0, mag}
                    : (potg_pkg::MAG_W + 2)'(potg_pkg::HALF_COLS) + {2'b0, mag};
  assign col_ok   = !col_s[potg_pkg::MAG_W+1]
                    && (col_s < (potg_pkg::MAG_W + 2)'(potg_pkg::GRID_COLS));

  assign q_ok = (32'(qrow_q) < potg_pkg::GRID_ROWS) && (32'(qcol_q) < potg_pkg::GRID_COLS);

  assign cell_sum = ram_rdata + potg_pkg::HIT_GAIN;

  always_comb begin
    ram_raddr = addr_q;
    if (state_q == S_DISP) begin
      ram_raddr = potg_pkg::ADDR_W'(qrow_q) * potg_pkg::ADDR_W'(potg_pkg::GRID_COLS)
                  + potg_pkg::ADDR_W'(qcol_q);
    end else if (state_q == S_COL) begin
      ram_raddr = potg_pkg::ADDR_W'(row_q) * potg_pkg::ADDR_W'(potg_pkg::GRID_COLS)
                  + potg_pkg::ADDR_W'(col_s[potg_pkg::COL_W-1:0]);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = cell_sum;
    if (state_q == S_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else if (state_q == S_UPD) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR: begin
        if (clr_cnt_q == potg_pkg::ADDR_W'(potg_pkg::DEPTH - 1)) begin
          state_d = clr_op_q ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: if (s_axis_tvalid) state_d = S_DISP;
      S_DISP: begin
        case (op_q)
          potg_pkg::OP_HIT:   state_d = S_DEN;
          potg_pkg::OP_CLEAR: state_d = S_CLR;
          potg_pkg::OP_READ:  state_d = q_ok ? S_QRD : S_DONE;
          default:            state_d = S_DONE;
        endcase
      end
      S_DEN:  state_d = den_pos ? S_DIV : S_DONE;
      S_DIV:  if (div_done) state_d = S_ROW;
      S_ROW:  state_d = row_ok ? S_MOD : S_DONE;
      S_MOD:  if (idx_q < potg_pkg::TURN_STEPS) state_d = S_MUL;
      S_MUL:  state_d = S_WAIT;
      S_WAIT: state_d = S_COL;
      S_COL:  state_d = col_ok ? S_UPD : S_DONE;
      S_UPD:  state_d = S_DONE;
      S_QRD:  state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_cnt_q   <= '0;
      clr_op_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end else if (state_q == S_DISP) begin
        clr_cnt_q <= '0;
        clr_op_q  <= 1'b1;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        op_q      <= potg_pkg::opcode_e'(s_axis_tuser);
        x_q       <= s_axis_tdata[10:0] & pix_mask;
        y_q       <= s_axis_tdata[21:11] & pix_mask;
        qrow_q    <= s_axis_tdata[28:22];
        qcol_q    <= s_axis_tdata[35:29];
        res_st_q  <= potg_pkg::ST_DONE;
        res_row_q <= '0;
        res_col_q <= '0;
        res_val_q <= '0;
      end
      S_DISP: begin
        num_q  <= dist_num_q * cells_pm_q;
        den_q  <= potg_pkg::DEN_W'({2'b0, y_q, 4'b0})
                  + {{(potg_pkg::DEN_W - 16){row_off_q[15]}}, row_off_q};
        bear_q <= potg_pkg::BEAR_W'(bear_gain_q * x_q)
                  + {{(potg_pkg::BEAR_W - 24){bear_off_q[15]}}, bear_off_q, 8'b0};
        if (op_q == potg_pkg::OP_READ) begin
          res_row_q <= qrow_q;
          res_col_q <= qcol_q;
          if (!q_ok) res_st_q <= potg_pkg::ST_OFF_GRID;
        end
      end
      S_DEN: begin
        if (!den_pos) res_st_q <= potg_pkg::ST_NO_DIST;
      end
      S_DIV: begin
        dq_q <= div_quo;
      end
      S_ROW: begin
        row_q <= row_sum[16 +: potg_pkg::ROW_W];
        idx_q <= bear_biased[12 +: MODW];
        if (!row_ok) res_st_q <= potg_pkg::ST_OFF_GRID;
      end
      S_MOD: begin
        // Reduce the step index one turn at a time, then look up the table
        if (idx_q >= potg_pkg::TURN_STEPS) begin
          idx_q <= idx_q - potg_pkg::TURN_STEPS;
        end else begin
          neg_q <= idx_q >= potg_pkg::HALF_STEPS;
          tan_q <= potg_pkg::TAN_TABLE[tan_addr];
        end
      end
      S_MUL: begin
        prod_q <= dq_q[potg_pkg::DQ_W-1:0] * tan_q;
      end
      S_COL: begin
        col_q  <= col_s[potg_pkg::COL_W-1:0];
        addr_q <= ram_raddr;
        if (!col_ok) res_st_q <= potg_pkg::ST_OFF_GRID;
      end
      S_UPD: begin
        res_row_q <= potg_pkg::FIELD_W'(row_q);
        res_col_q <= potg_pkg::FIELD_W'(col_q);
        res_val_q <= cell_sum;
      end
      S_QRD: begin
        res_val_q <= ram_rdata;
      end
      S_DONE: begin
        if (out_free) begin
          out_st_q  <= res_st_q;
          out_row_q <= res_row_q;
          out_col_q <= res_col_q;
          out_val_q <= res_val_q;
        end
      end
      default: ;
    endcase
  end

  potg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   ({den_q[potg_pkg::DEN_W-2:0], 1'b0}),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  potg_ram #(
    .WIDTH (potg_pkg::CELL_W),
    .DEPTH (potg_pkg::DEPTH)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tdata  = {2'b0, out_val_q, out_col_q, out_row_q};

  a_upd_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> (ram_waddr == $past(ram_raddr)))
    else $error("cell update address differs from the read address");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide phase");

  a_no_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == potg_pkg::ST_NO_DIST)) |-> (m_axis_tdata == '0))
    else $error("no-distance result carries cell data");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result loaded outside the done phase");

endmodule

FILE: verif/pixel_to_occupancy_grid_accumulator_unit_tb.sv
`timescale 1ns / 1ps

module pixel_to_occupancy_grid_accumulator_unit_tb;

  typedef struct {
    potg_pkg::opcode_e op;
    logic [10:0] px;
    logic [10:0] py;
    logic [6:0]  qr;
    logic [6:0]  qc;
  } occ_req_t;

  typedef struct {
    potg_pkg::status_e st;
    logic [6:0]  row;
    logic [6:0]  col;
    logic [7:0]  value;
  } occ_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [23:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  pixel_to_occupancy_grid_accumulator_unit dut (.*);

  always #4 clk_i = ~clk_i;

  // shadow copy of the block's state
  longint      tan_lut [0:potg_pkg::TAN_STEPS];
  byte         occ_grid [potg_pkg::GRID_ROWS*potg_pkg::GRID_COLS];
  logic [23:0] dist_num;
  logic [15:0] row_off, bear_gain, bear_off, cells_pm;
  int          last_row, last_col;

  occ_result_t expected_cells [$];
  int          mismatches = 0;
  int          src_idle_pct = 0;
  int          sink_idle_pct = 0;
  logic        hold_req = 1'b0;
  int          hold_left = 0;

  function automatic void fill_tan_lut();
    longint x, ts, tc, s, c, t;
    for (int k = 0; k < potg_pkg::TAN_STEPS; k++) begin
      x  = (longint'(k) * 64'sd3373259426 + potg_pkg::TAN_STEPS) / (2 * potg_pkg::TAN_STEPS);
      ts = x;
      tc = 64'sd1073741824;
      s  = x;
      c  = tc;
      for (int n = 1; n <= 10; n++) begin
        ts = (((ts * x) >>> 30) * x >>> 30) / ((2 * n) * (2 * n + 1));
        tc = (((tc * x) >>> 30) * x >>> 30) / ((2 * n - 1) * (2 * n));
        if (n % 2 == 1) begin
          s -= ts;
          c -= tc;
        end else begin
          s += ts;
          c += tc;
        end
      end
      if (s < 0) s = 0;
      if (c <= 0) t = 16777215;
      else t = (s * 65536 + c / 2) / c;
      tan_lut[k] = (t > 16777215) ? 16777215 : t;
    end
    tan_lut[potg_pkg::TAN_STEPS] = 16777215;
  endfunction

  function automatic occ_result_t predict_occupancy(occ_req_t rq);
    occ_result_t rs;
    longint den, dq, row, bear, idx, t, mag, col;
    int cell_idx;
    rs = '{potg_pkg::ST_DONE, 7'd0, 7'd0, 8'd0};
    case (rq.op)
      potg_pkg::OP_CLEAR: begin
        foreach (occ_grid[i]) occ_grid[i] = 0;
      end
      potg_pkg::OP_READ: begin
        rs.row = rq.qr;
        rs.col = rq.qc;
        rs.value = occ_grid[int'(rq.qr) * potg_pkg::GRID_COLS + int'(rq.qc)];
      end
      potg_pkg::OP_HIT: begin
        den = longint'(rq.py) * 16 + longint'($signed(row_off));
        if (den <= 0) begin
          rs.st = potg_pkg::ST_NO_DIST;
          return rs;
        end
        dq  = (2 * longint'(dist_num) * longint'(cells_pm) * 16 + den) / (2 * den);
        row = (dq + 32768) >>> 16;
        if (row >= potg_pkg::GRID_ROWS) begin
          rs.st = potg_pkg::ST_OFF_GRID;
          return rs;
        end
        bear = longint'(bear_gain) * longint'(rq.px) + longint'($signed(bear_off)) * 256;
        idx  = ((bear + 2048 + 4096 * 2 * potg_pkg::TAN_STEPS) / 4096)
               % (2 * potg_pkg::TAN_STEPS);
        t    = (idx >= potg_pkg::TAN_STEPS) ? -tan_lut[2 * potg_pkg::TAN_STEPS - idx]
                                            : tan_lut[idx];
        mag  = (dq * (t < 0 ? -t : t) + (longint'(1) << 31)) >>> 32;
        col  = (t < 0 ? -mag : mag) + potg_pkg::GRID_COLS / 2;
        if (col < 0 || col >= potg_pkg::GRID_COLS) begin
          rs.st = potg_pkg::ST_OFF_GRID;
          return rs;
        end
        cell_idx = int'(row) * potg_pkg::GRID_COLS + int'(col);
        occ_grid[cell_idx] = byte'(occ_grid[cell_idx] + 80);
        last_row = int'(row);
        last_col = int'(col);
        rs.row = 7'(row);
        rs.col = 7'(col);
        rs.value = occ_grid[cell_idx];
      end
      default: ;
    endcase
    return rs;
  endfunction

  // long receiver hold-off, counted here
  always @(posedge clk_i) begin
    if (hold_req) hold_left <= 600;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // receiver: random stalls and result check
  always @(posedge clk_i) begin
    occ_result_t exp_r;
    if (rst_ni) begin
      m_axis_tready <= (hold_left == 0) && !hold_req &&
                       ($urandom_range(0, 99) >= sink_idle_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_cells.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h/%h", m_axis_tuser, m_axis_tdata);
        end else begin
          exp_r = expected_cells.pop_front();
          if (m_axis_tuser !== exp_r.st || m_axis_tdata[6:0] !== exp_r.row ||
              m_axis_tdata[13:7] !== exp_r.col || m_axis_tdata[21:14] !== exp_r.value ||
              m_axis_tdata[23:22] !== 2'b00) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp st %0d row %0d col %0d val %0d, got st %0d tdata %h",
                       exp_r.st, exp_r.row, exp_r.col, $signed(exp_r.value),
                       m_axis_tuser, m_axis_tdata);
          end
        end
      end
    end
  end

  task automatic send_request(occ_req_t rq);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < src_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= rq.op;
    s_axis_tdata  <= {4'b0, rq.qc, rq.qr, rq.py, rq.px};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_cells.push_back(predict_occupancy(rq));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      potg_pkg::REG_DIST_NUM:   dist_num  = val;
      potg_pkg::REG_ROW_OFFSET: row_off   = val[15:0];
      potg_pkg::REG_BEAR_GAIN:  bear_gain = val[15:0];
      potg_pkg::REG_BEAR_OFF:   bear_off  = val[15:0];
      potg_pkg::REG_CELLS_PM:   cells_pm  = val[15:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(logic [23:0] a, logic [15:0] b, logic [15:0] g,
                           logic [15:0] d, logic [15:0] cpm);
    write_reg(potg_pkg::REG_DIST_NUM, a);
    write_reg(potg_pkg::REG_ROW_OFFSET, {8'b0, b});
    write_reg(potg_pkg::REG_BEAR_GAIN, {8'b0, g});
    write_reg(potg_pkg::REG_BEAR_OFF, {8'b0, d});
    write_reg(potg_pkg::REG_CELLS_PM, {8'b0, cpm});
  endtask

  function automatic occ_req_t make_hit(int px, int py);
    occ_req_t rq;
    rq = '{potg_pkg::OP_HIT, 11'(px), 11'(py), 7'($urandom), 7'($urandom)};
    return rq;
  endfunction

  function automatic occ_req_t random_request(bit allow_clear);
    occ_req_t rq;
    int sel;
    sel = $urandom_range(0, 999);
    rq = '{potg_pkg::OP_HIT, 11'($urandom), 11'($urandom), 7'($urandom), 7'($urandom)};
    if (sel < 5 && allow_clear) begin
      rq.op = potg_pkg::OP_CLEAR;
    end else if (sel < 40) begin
      rq.op = potg_pkg::OP_NOP;
    end else if (sel < 260) begin
      rq.op = potg_pkg::OP_READ;
      if ($urandom_range(0, 99) < 70) begin
        rq.qr = 7'(last_row);
        rq.qc = 7'(last_col);
      end
    end else if (sel < 800) begin
      // mostly ground-plane rows that land on the grid
      rq.py = 11'($urandom_range(330, 900));
    end
    return rq;
  endfunction

  task automatic test_directed();
    occ_req_t rq;
    send_request(make_hit(0, 0));
    send_request(make_hit(2047, 2047));
    send_request(make_hit(1000, 300));
    send_request(make_hit(1000, 301));
    send_request(make_hit(617, 342));
    send_request(make_hit(0, 500));
    send_request(make_hit(2047, 500));
    send_request(make_hit(1365, 2047));
    repeat (4) send_request(make_hit(617, 420));
    rq = '{potg_pkg::OP_READ, 11'h7ff, 11'h0, 7'(last_row), 7'(last_col)};
    send_request(rq);
    send_request('{potg_pkg::OP_READ, 11'h0, 11'h7ff, 7'd0, 7'd0});
    send_request('{potg_pkg::OP_READ, 11'h0, 11'h0, 7'd127, 7'd127});
    send_request('{potg_pkg::OP_NOP, 11'h7ff, 11'h7ff, 7'd127, 7'd127});
    send_request('{potg_pkg::OP_CLEAR, 11'h0, 11'h0, 7'd0, 7'd0});
    send_request('{potg_pkg::OP_READ, 11'h0, 11'h0, 7'(last_row), 7'(last_col)});
  endtask

  task automatic test_random(int n, int src_pct, int sink_pct);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    for (int i = 0; i < n; i++) send_request(random_request(1'b1));
  endtask

  task automatic test_register_extremes();
    src_idle_pct  = 10;
    sink_idle_pct = 10;
    load_regs(24'h0, 16'h8000, 16'h0, 16'h8000, 16'h1);
    for (int i = 0; i < 50; i++) send_request(random_request(1'b0));
    load_regs(24'hffffff, 16'h7fff, 16'hffff, 16'h7fff, 16'hffff);
    for (int i = 0; i < 50; i++) send_request(random_request(1'b0));
    load_regs(24'($urandom_range(20000, 120000)), 16'(-$urandom_range(3000, 8000)),
              16'($urandom), 16'($urandom), 16'($urandom_range(1000, 10000)));
    for (int i = 0; i < 60; i++) send_request(random_request(1'b0));
    // index past the register list must be ignored
    write_reg(3'd5, 24'hffffff);
    write_reg(3'd7, 24'h000000);
    load_regs(potg_pkg::RST_DIST_NUM, potg_pkg::RST_ROW_OFFSET, potg_pkg::RST_BEAR_GAIN,
              potg_pkg::RST_BEAR_OFF, potg_pkg::RST_CELLS_PM);
  endtask

  task automatic test_backpressure();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_req <= 1'b1;
    @(posedge clk_i);
    hold_req <= 1'b0;
    for (int i = 0; i < 12; i++) send_request(random_request(1'b0));
    // sender pauses until every result is back
    wait_drained();
    for (int i = 0; i < 8; i++) send_request(random_request(1'b0));
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= potg_pkg::REG_DIST_NUM;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= potg_pkg::OP_NOP;
    fill_tan_lut();
    foreach (occ_grid[i]) occ_grid[i] = 0;
    dist_num  = potg_pkg::RST_DIST_NUM;
    row_off   = potg_pkg::RST_ROW_OFFSET;
    bear_gain = potg_pkg::RST_BEAR_GAIN;
    bear_off  = potg_pkg::RST_BEAR_OFF;
    cells_pm  = potg_pkg::RST_CELLS_PM;
    last_row  = 0;
    last_col  = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(280, 28, 53);
    test_register_extremes();
    test_random(280, 53, 28);
    test_backpressure();
    test_random(280, 0, 0);

    wait_drained();
    if (mismatches == 0 && expected_cells.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: files.f
rtl/potg_pkg.sv
rtl/potg_ram.sv
rtl/potg_div.sv
rtl/pixel_to_occupancy_grid_accumulator_unit.sv
verif/pixel_to_occupancy_grid_accumulator_unit_tb.sv
